// ===== sv/tbo_pkg.sv =====
// Package for the triangle/box overlap test: register indexes and shared types.
// No dependencies.
`default_nettype none
package tbo_pkg;
   typedef enum logic [1:0] {
      REG_HALF_X = 2'd0,
      REG_HALF_Y = 2'd1,
      REG_HALF_Z = 2'd2
   } reg_index_type;
   localparam int CSR_INDEX_WIDTH = 2;
endpackage
`default_nettype wire

// ===== sv/tbo_core.sv =====
// Pipelined separating-axis datapath: translate, edges, products, sums, compare.
// Depends on tbo_pkg; advances all stages together under an enable.
`default_nettype none
module tbo_core #(
   parameter int COORD_WIDTH = 32
) (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         advance,
   input  wire logic                         in_valid,
   input  wire logic signed [COORD_WIDTH-1:0] in_c [3],
   input  wire logic signed [COORD_WIDTH-1:0] in_v [3][3],
   input  wire logic [COORD_WIDTH-2:0]        in_h [3],
   output logic                              out_valid,
   output logic                              out_hit
);
   import tbo_pkg::*;
   localparam int VW = COORD_WIDTH + 1;
   localparam int EW = COORD_WIDTH + 2;
   localparam int PW = VW + EW;
   localparam int SW = PW + 1;
   localparam int NW = 2 * EW + 1;
   localparam int DW = VW + 1;
   localparam int QW = NW + DW;
   localparam int TW = QW + 2;
   localparam int LW = COORD_WIDTH + 3;
   localparam int QLW = LW + 1 + DW;
   localparam int QHW = NW - LW + DW;
   localparam int NSTG = 7;

   logic [NSTG-1:0] vld_ff;

   // stage 1: translate
   logic signed [VW-1:0] v1_ff [3][3];
   logic signed [VW-1:0] h1_ff [3];
   // stage 2: edges
   logic signed [VW-1:0] v2_ff [3][3];
   logic signed [EW-1:0] e2_ff [3][3];
   logic signed [VW-1:0] h2_ff [3];
   // stage 3: products
   logic signed [PW-1:0] pa_ff [3][3][3];
   logic signed [PW-1:0] pb_ff [3][3][3];
   logic signed [PW-1:0] ra_ff [3][3];
   logic signed [PW-1:0] rb_ff [3][3];
   logic signed [NW-2:0] na_ff [3];
   logic signed [NW-2:0] nb_ff [3];
   logic                 box3_ff;
   logic signed [VW-1:0] v3_ff [3];
   logic signed [VW-1:0] h3_ff [3];
   // stage 4: projections and normal
   logic                 sep4_ff;
   logic signed [NW-1:0] n4_ff [3];
   logic signed [DW-1:0] lo4_ff [3];
   logic signed [DW-1:0] hi4_ff [3];
   // stage 5: plane partial products
   logic                  sep5_ff;
   logic signed [QLW-1:0] qlmin5_ff [3];
   logic signed [QLW-1:0] qlmax5_ff [3];
   logic signed [QHW-1:0] qhmin5_ff [3];
   logic signed [QHW-1:0] qhmax5_ff [3];
   // stage 6: plane products
   logic                 sep6_ff;
   logic signed [QW-1:0] qmin6_ff [3];
   logic signed [QW-1:0] qmax6_ff [3];
   // stage 7: result
   logic                 hit7_ff;

   logic signed [VW-1:0] v1_in [3][3];
   logic signed [EW-1:0] e2_in [3][3];
   logic                 box3_in;
   logic signed [SW-1:0] p_sum [3][3][3];
   logic signed [SW-1:0] r_sum [3][3];
   logic                 sep4_in;
   logic signed [DW-1:0] lo4_in [3];
   logic signed [DW-1:0] hi4_in [3];
   logic signed [TW-1:0] smin, smax;

   always_comb begin
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            v1_in[a][k] = VW'(in_v[a][k]) - VW'(in_c[k]);
            e2_in[a][k] = EW'(v1_ff[(a + 1) % 3][k]) - EW'(v1_ff[a][k]);
         end
      end
   end

   always_comb begin
      box3_in = 1'b0;
      for (int k = 0; k < 3; k++) begin
         if (v2_ff[0][k] > h2_ff[k] && v2_ff[1][k] > h2_ff[k] && v2_ff[2][k] > h2_ff[k]) begin
            box3_in = 1'b1;
         end
         if (v2_ff[0][k] < -h2_ff[k] && v2_ff[1][k] < -h2_ff[k]
               && v2_ff[2][k] < -h2_ff[k]) begin
            box3_in = 1'b1;
         end
      end
   end

   always_comb begin
      sep4_in = box3_ff;
      for (int a = 0; a < 3; a++) begin
         for (int k = 0; k < 3; k++) begin
            r_sum[a][k] = SW'(ra_ff[a][k]) + SW'(rb_ff[a][k]);
            for (int n = 0; n < 3; n++) begin
               p_sum[a][k][n] = SW'(pa_ff[a][k][n]) - SW'(pb_ff[a][k][n]);
            end
            if (p_sum[a][k][0] > r_sum[a][k] && p_sum[a][k][1] > r_sum[a][k]
                  && p_sum[a][k][2] > r_sum[a][k]) begin
               sep4_in = 1'b1;
            end
            if (p_sum[a][k][0] < -r_sum[a][k] && p_sum[a][k][1] < -r_sum[a][k]
                  && p_sum[a][k][2] < -r_sum[a][k]) begin
               sep4_in = 1'b1;
            end
         end
      end
      for (int k = 0; k < 3; k++) begin
         if (NW'(na_ff[k]) - NW'(nb_ff[k]) > 0) begin
            lo4_in[k] = -DW'(h3_ff[k]) - DW'(v3_ff[k]);
            hi4_in[k] = DW'(h3_ff[k]) - DW'(v3_ff[k]);
         end else begin
            lo4_in[k] = DW'(h3_ff[k]) - DW'(v3_ff[k]);
            hi4_in[k] = -DW'(h3_ff[k]) - DW'(v3_ff[k]);
         end
      end
   end

   always_comb begin
      smin = TW'(qmin6_ff[0]) + TW'(qmin6_ff[1]) + TW'(qmin6_ff[2]);
      smax = TW'(qmax6_ff[0]) + TW'(qmax6_ff[1]) + TW'(qmax6_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v1_ff <= v1_in;
         for (int k = 0; k < 3; k++) begin
            h1_ff[k] <= VW'({1'b0, in_h[k]});
         end
         v2_ff <= v1_ff;
         e2_ff <= e2_in;
         h2_ff <= h1_ff;
         for (int a = 0; a < 3; a++) begin
            for (int k = 0; k < 3; k++) begin
               ra_ff[a][k] <= PW'(e2_ff[a][(k + 1) % 3] < 0 ? -e2_ff[a][(k + 1) % 3]
                                  : e2_ff[a][(k + 1) % 3]) * PW'(h2_ff[(k + 2) % 3]);
               rb_ff[a][k] <= PW'(e2_ff[a][(k + 2) % 3] < 0 ? -e2_ff[a][(k + 2) % 3]
                                  : e2_ff[a][(k + 2) % 3]) * PW'(h2_ff[(k + 1) % 3]);
               for (int n = 0; n < 3; n++) begin
                  pa_ff[a][k][n] <= PW'(e2_ff[a][(k + 2) % 3]) * PW'(v2_ff[n][(k + 1) % 3]);
                  pb_ff[a][k][n] <= PW'(e2_ff[a][(k + 1) % 3]) * PW'(v2_ff[n][(k + 2) % 3]);
               end
            end
         end
         for (int k = 0; k < 3; k++) begin
            na_ff[k] <= (NW-1)'(e2_ff[0][(k + 1) % 3]) * (NW-1)'(e2_ff[1][(k + 2) % 3]);
            nb_ff[k] <= (NW-1)'(e2_ff[0][(k + 2) % 3]) * (NW-1)'(e2_ff[1][(k + 1) % 3]);
            v3_ff[k] <= v2_ff[0][k];
            n4_ff[k] <= NW'(na_ff[k]) - NW'(nb_ff[k]);
            qlmin5_ff[k] <= QLW'($signed({1'b0, n4_ff[k][LW-1:0]})) * QLW'(lo4_ff[k]);
            qlmax5_ff[k] <= QLW'($signed({1'b0, n4_ff[k][LW-1:0]})) * QLW'(hi4_ff[k]);
            qhmin5_ff[k] <= QHW'($signed(n4_ff[k][NW-1:LW])) * QHW'(lo4_ff[k]);
            qhmax5_ff[k] <= QHW'($signed(n4_ff[k][NW-1:LW])) * QHW'(hi4_ff[k]);
            qmin6_ff[k] <= (QW'(qhmin5_ff[k]) <<< LW) + QW'(qlmin5_ff[k]);
            qmax6_ff[k] <= (QW'(qhmax5_ff[k]) <<< LW) + QW'(qlmax5_ff[k]);
         end
         box3_ff <= box3_in;
         h3_ff <= h2_ff;
         sep4_ff <= sep4_in;
         lo4_ff <= lo4_in;
         hi4_ff <= hi4_in;
         sep5_ff <= sep4_ff;
         sep6_ff <= sep5_ff;
         hit7_ff <= !sep6_ff && !(smin > 0) && !(smax < 0);
      end
   end

   assign out_valid = vld_ff[NSTG-1];
   assign out_hit = hit7_ff;
endmodule
`default_nettype wire

// ===== sv/triangle_box_overlap_test_top.sv =====
// Throughput one request per cycle whenever the pipeline advances.
// The pipeline advances whenever its last stage is empty or being taken.
// Reset clears valid bits and sets every half size to 0.5 (Q16.16).
// Top level: handshakes and half-size registers; depends on tbo_pkg and tbo_core.
`default_nettype none
module triangle_box_overlap_test_top #(
   parameter int COORD_WIDTH = 32,
   parameter int FRAC_BITS = 16
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output logic                                       req_ready,
   input  wire logic signed [COORD_WIDTH-1:0]         req_center_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_center_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_center_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_a_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_a_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_a_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_b_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_b_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_b_z,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_c_x,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_c_y,
   input  wire logic signed [COORD_WIDTH-1:0]         req_vert_c_z,
   output logic                                       rsp_valid,
   input  wire logic                                  rsp_ready,
   output logic                                       rsp_overlaps,
   input  wire logic                                  csr_valid,
   output logic                                       csr_ready,
   input  wire logic [tbo_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  wire logic [COORD_WIDTH-2:0]                csr_data
);
   import tbo_pkg::*;
   localparam logic [COORD_WIDTH-2:0] HALF_RESET = (COORD_WIDTH-1)'((64'd1 << FRAC_BITS) >> 1);

   logic [COORD_WIDTH-2:0] half_ff [3];
   logic signed [COORD_WIDTH-1:0] c_bus [3];
   logic signed [COORD_WIDTH-1:0] v_bus [3][3];
   logic advance;

   assign advance = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_ff[0] <= HALF_RESET;
         half_ff[1] <= HALF_RESET;
         half_ff[2] <= HALF_RESET;
      end else if (csr_valid) begin
         case (csr_index)
            REG_HALF_X: half_ff[0] <= csr_data;
            REG_HALF_Y: half_ff[1] <= csr_data;
            REG_HALF_Z: half_ff[2] <= csr_data;
            default: ;
         endcase
      end
   end

   assign c_bus = '{req_center_x, req_center_y, req_center_z};
   assign v_bus = '{'{req_vert_a_x, req_vert_a_y, req_vert_a_z},
                    '{req_vert_b_x, req_vert_b_y, req_vert_b_z},
                    '{req_vert_c_x, req_vert_c_y, req_vert_c_z}};

   tbo_core #(.COORD_WIDTH(COORD_WIDTH)) u_core (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .in_valid  (req_valid),
      .in_c      (c_bus),
      .in_v      (v_bus),
      .in_h      (half_ff),
      .out_valid (rsp_valid),
      .out_hit   (rsp_overlaps)
   );
endmodule
`default_nettype wire

// ===== bench/triangle_box_overlap_test_top_tb.sv =====
// Self-checking bench for triangle_box_overlap_test_top: random and directed triangle/box
// requests are checked against a bit-exact fixed-point separating-axis predictor.
// Depends on tbo_pkg and the block's RTL.
`default_nettype none
module triangle_box_overlap_test_top_tb;
   import tbo_pkg::*;

   typedef logic signed [191:0] wide_type;
   typedef struct {
      logic signed [31:0] c[3];
      logic signed [31:0] v[3][3];
   } tri_req_type;

   localparam logic [CSR_INDEX_WIDTH-1:0] REG_UNUSED = 2'd3;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 12;

   class overlap_scoreboard;
      longint hsize[3];
      bit     expected_overlaps[$];
      int     errors;

      function new();
         hsize = '{32768, 32768, 32768};
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_WIDTH-1:0] idx, logic [30:0] data);
         if (idx == REG_HALF_X) hsize[0] = longint'(data);
         else if (idx == REG_HALF_Y) hsize[1] = longint'(data);
         else if (idx == REG_HALF_Z) hsize[2] = longint'(data);
      endfunction

      function bit predict_overlap(tri_req_type t);
         longint v[3][3], e[3][3], lo, hi, ai, aj;
         wide_type p, wlo, whi, rad, nrm[3], dmin, dmax;
         int i, j;
         bit hit;
         for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++)
               v[a][k] = longint'(t.v[a][k]) - longint'(t.c[k]);
         for (int k = 0; k < 3; k++) begin
            e[0][k] = v[1][k] - v[0][k];
            e[1][k] = v[2][k] - v[1][k];
            e[2][k] = v[0][k] - v[2][k];
         end
         hit = 1;
         for (int a = 0; a < 3; a++)
            for (int k = 0; k < 3; k++) begin
               i = (k + 1) % 3;
               j = (k + 2) % 3;
               for (int n = 0; n < 3; n++) begin
                  p = wide_type'(e[a][j]) * wide_type'(v[n][i])
                      - wide_type'(e[a][i]) * wide_type'(v[n][j]);
                  if (n == 0 || p < wlo) wlo = p;
                  if (n == 0 || p > whi) whi = p;
               end
               ai = e[a][i] < 0 ? -e[a][i] : e[a][i];
               aj = e[a][j] < 0 ? -e[a][j] : e[a][j];
               rad = wide_type'(ai) * wide_type'(hsize[j]) + wide_type'(aj) * wide_type'(hsize[i]);
               if (wlo > rad || whi < -rad) hit = 0;
            end
         for (int k = 0; k < 3; k++) begin
            lo = v[0][k];
            hi = v[0][k];
            for (int a = 1; a < 3; a++) begin
               if (v[a][k] < lo) lo = v[a][k];
               if (v[a][k] > hi) hi = v[a][k];
            end
            if (lo > hsize[k] || hi < -hsize[k]) hit = 0;
         end
         dmin = 0;
         dmax = 0;
         for (int k = 0; k < 3; k++) begin
            i = (k + 1) % 3;
            j = (k + 2) % 3;
            nrm[k] = wide_type'(e[0][i]) * wide_type'(e[1][j])
                     - wide_type'(e[0][j]) * wide_type'(e[1][i]);
            if (nrm[k] > 0) begin
               lo = -hsize[k] - v[0][k];
               hi = hsize[k] - v[0][k];
            end else begin
               lo = hsize[k] - v[0][k];
               hi = -hsize[k] - v[0][k];
            end
            dmin = dmin + nrm[k] * wide_type'(lo);
            dmax = dmax + nrm[k] * wide_type'(hi);
         end
         if (dmin > 0 || dmax < 0) hit = 0;
         return hit;
      endfunction

      function void note_request(tri_req_type t);
         expected_overlaps = {expected_overlaps, predict_overlap(t)};
      endfunction

      function void check_result(bit actual);
         bit exp_val;
         if (expected_overlaps.size() == 0) begin
            $error("overlaps: unexpected result, actual %0d", actual);
            errors++;
            return;
         end
         exp_val = expected_overlaps.pop_front();
         if (exp_val !== actual) begin
            $error("overlaps: expected %0d, actual %0d", exp_val, actual);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_ready, rsp_valid, rsp_ready, rsp_overlaps;
   logic csr_valid, csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [30:0] csr_data;
   tri_req_type cur_req;
   overlap_scoreboard sb;
   int cycle_count;
   bit hold_rsp;

   triangle_box_overlap_test_top i_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready),
      .req_center_x(cur_req.c[0]), .req_center_y(cur_req.c[1]), .req_center_z(cur_req.c[2]),
      .req_vert_a_x(cur_req.v[0][0]), .req_vert_a_y(cur_req.v[0][1]),
      .req_vert_a_z(cur_req.v[0][2]),
      .req_vert_b_x(cur_req.v[1][0]), .req_vert_b_y(cur_req.v[1][1]),
      .req_vert_b_z(cur_req.v[1][2]),
      .req_vert_c_x(cur_req.v[2][0]), .req_vert_c_y(cur_req.v[2][1]),
      .req_vert_c_z(cur_req.v[2][2]),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_overlaps(rsp_overlaps),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      rsp_ready = 0;
      csr_valid = 0;
      csr_index = REG_HALF_X;
      csr_data = 0;
      hold_rsp = 0;
      cycle_count = 0;
      for (int k = 0; k < 3; k++) begin
         cur_req.c[k] = 0;
         for (int a = 0; a < 3; a++) cur_req.v[a][k] = 0;
      end
      sb = new();
   end

   always begin
      #6 clock = 1;
      #6 clock = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   always @(posedge clock)
      if (!reset && rsp_valid && rsp_ready) sb.check_result(rsp_overlaps);

   initial begin : rsp_side
      int r, len;
      @(negedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_ready <= 0;
            repeat (200) @(negedge clock);
            hold_rsp = 0;
         end else begin
            r = $urandom_range(0, 99);
            len = $urandom_range(1, 8);
            if (r < 25) rsp_ready <= 1;
            else if (r < 60) rsp_ready <= 1;
            else if (r < 95) rsp_ready <= 0;
            else begin
               rsp_ready <= 0;
               len = $urandom_range(20, 60);
            end
            repeat (len) @(negedge clock);
         end
      end
   end

   task automatic send_req(tri_req_type t, int gap);
      @(negedge clock);
      cur_req <= t;
      req_valid <= 1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(t);
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 0;
      while (sb.expected_overlaps.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_WIDTH-1:0] idx, logic [30:0] data);
      wait_drained();
      @(negedge clock);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      do @(posedge clock); while (!csr_ready);
      sb.write_reg(idx, data);
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic set_box(logic [30:0] hx, logic [30:0] hy, logic [30:0] hz);
      write_csr(REG_HALF_X, hx);
      write_csr(REG_HALF_Y, hy);
      write_csr(REG_HALF_Z, hz);
   endtask

   function automatic tri_req_type make_req(bit noise);
      tri_req_type t;
      longint span;
      span = sb.hsize[0];
      if (sb.hsize[1] > span) span = sb.hsize[1];
      if (sb.hsize[2] > span) span = sb.hsize[2];
      span = span + $urandom_range(1, 131072);
      if (span > (1 << 27)) span = 1 << 27;
      if ($urandom_range(0, 3) == 0) span = $urandom_range(1, 65536);
      for (int k = 0; k < 3; k++) begin
         t.c[k] = noise ? $urandom : int'($urandom_range(0, 1 << 30)) - (1 << 29);
         for (int a = 0; a < 3; a++)
            t.v[a][k] = noise ? $urandom
                        : t.c[k] + int'($urandom_range(0, 4 * span)) - 2 * int'(span);
      end
      return t;
   endfunction

   function automatic tri_req_type fill_req(logic signed [31:0] cval, logic signed [31:0] vval);
      tri_req_type t;
      for (int k = 0; k < 3; k++) begin
         t.c[k] = cval;
         for (int a = 0; a < 3; a++) t.v[a][k] = vval;
      end
      return t;
   endfunction

   task automatic random_phase(int count);
      repeat (count) send_req(make_req($urandom_range(0, 9) == 0), pick_gap());
   endtask

   initial begin : stimulus
      tri_req_type t;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      // extremes and degenerate triangles
      send_req(fill_req(32'sh80000000, 32'sh7fffffff), 0);
      send_req(fill_req(32'sh7fffffff, 32'sh80000000), 0);
      send_req(fill_req(32'sh80000000, 32'sh80000000), 0);
      send_req(fill_req(32'sh7fffffff, 32'sh7fffffff), 1);
      send_req(fill_req(0, 0), 0);
      t = fill_req(0, 0);
      t.v[0] = '{32'sh80000000, 32'sh7fffffff, 32'sh80000000};
      t.v[1] = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff};
      t.v[2] = '{32'sh7fffffff, 32'sh7fffffff, 32'sh80000000};
      send_req(t, 0);
      // touching a box face exactly
      t = fill_req(0, 0);
      t.v[0] = '{32768, 0, 0};
      t.v[1] = '{65536, 0, 0};
      t.v[2] = '{65536, 65536, 0};
      send_req(t, 0);
      t.v[0] = '{32769, 0, 0};
      send_req(t, 2);
      // collinear triangle through the box
      t.v[0] = '{-65536, -65536, -65536};
      t.v[1] = '{0, 0, 0};
      t.v[2] = '{65536, 65536, 65536};
      send_req(t, 0);
      // large triangle whose plane misses the box corner
      t.v[0] = '{131072, 0, 0};
      t.v[1] = '{0, 131072, 0};
      t.v[2] = '{0, 0, 131072};
      send_req(t, 0);
      t.v[0] = '{98304, 0, 0};
      t.v[1] = '{0, 98304, 0};
      t.v[2] = '{0, 0, 98304};
      send_req(t, 0);
      random_phase(80);

      set_box(31'h7fffffff, 31'h7fffffff, 31'h7fffffff);
      send_req(fill_req(32'sh80000000, 32'sh7fffffff), 0);
      send_req(fill_req(0, 32'sh7fffffff), 0);
      random_phase(60);

      set_box(31'd0, 31'd0, 31'd0);
      send_req(fill_req(0, 0), 0);
      t = fill_req(0, 0);
      t.v[0] = '{-65536, 0, 0};
      t.v[1] = '{65536, 0, 0};
      t.v[2] = '{0, 65536, 0};
      send_req(t, 0);
      random_phase(60);

      write_csr(REG_UNUSED, 31'($urandom));
      set_box(31'($urandom), 31'($urandom), 31'($urandom));
      random_phase(20);

      // stall the response side so the pipeline backs up into the request side
      @(negedge clock);
      req_valid <= 0;
      hold_rsp = 1;
      repeat (40) send_req(make_req(0), 0);
      wait_drained();

      set_box(31'($urandom_range(0, 200000)), 31'($urandom_range(0, 200000)),
              31'($urandom_range(0, 200000)));
      random_phase(80);
      set_box(31'd32768, 31'($urandom_range(0, 1000)), 31'h7fffffff);
      random_phase(60);

      @(negedge clock);
      req_valid <= 0;
      wait_drained();
      if (sb.errors == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end
endmodule
`default_nettype wire
